### hdl/bsd_pkg.sv
// bsd_pkg: shared constants, codes and result type for the binary stl deframer
// no dependencies; used by every other file of the block but bsd_stream_if
package bsd_pkg;

  localparam int unsigned HEADER_BYTES   = 80;
  localparam int unsigned PREAMBLE_BYTES = 84;
  localparam int unsigned RECORD_BYTES   = 50;
  localparam int unsigned WORD_BYTES     = 48;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] float_word;
    logic [3:0]  word_slot;
    logic [31:0] triangle_number;
    status_t     file_status;
  } result_t;

endpackage

### hdl/bsd_stream_if.sv
// bsd_stream_if: valid/ready channels for input bytes and result words
// depends on nothing; payload widths fixed by the file format
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] float_word;
  logic [3:0]  word_slot;
  logic [31:0] triangle_number;
  logic [1:0]  file_status;

  modport source (output valid, result_kind, float_word, word_slot, triangle_number,
                  file_status, input ready);
  modport sink (input valid, result_kind, float_word, word_slot, triangle_number,
                file_status, output ready);
endinterface

### hdl/bsd_parser.sv
// bsd_parser: header skip, count assembly, record walk and word assembly
// depends on bsd_pkg; one byte taken per accept, at most one result out
module bsd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              res_valid,
  output bsd_pkg::result_t  res
);

  logic [6:0]  header_position, header_position_next;
  logic [31:0] declared_count, declared_count_next;
  logic [5:0]  record_position, record_position_next;
  logic [31:0] triangles_seen, triangles_seen_next;
  logic [23:0] partial_word, partial_word_next;
  logic        excess_seen, excess_seen_next;
  logic        word_hit;
  logic        below_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      declared_count  <= '0;
      record_position <= '0;
      triangles_seen  <= '0;
      partial_word    <= '0;
      excess_seen     <= 1'b0;
    end else if (accept) begin
      header_position <= header_position_next;
      declared_count  <= declared_count_next;
      record_position <= record_position_next;
      triangles_seen  <= triangles_seen_next;
      partial_word    <= partial_word_next;
      excess_seen     <= excess_seen_next;
    end
  end

  always_comb begin
    header_position_next = header_position;
    declared_count_next  = declared_count;
    record_position_next = record_position;
    triangles_seen_next  = triangles_seen;
    partial_word_next    = partial_word;
    excess_seen_next     = excess_seen;
    word_hit             = 1'b0;
    below_count          = triangles_seen < declared_count;

    res.result_kind     = bsd_pkg::KIND_WORD;
    res.float_word      = {data_byte, partial_word};
    res.word_slot       = record_position[5:2];
    res.triangle_number = triangles_seen;
    res.file_status     = bsd_pkg::STATUS_OK;

    if (header_position < 7'(bsd_pkg::PREAMBLE_BYTES)) begin
      if (header_position >= 7'(bsd_pkg::HEADER_BYTES)) begin
        declared_count_next = declared_count
                              | (32'(data_byte) << {header_position[1:0], 3'b000});
      end
      header_position_next = header_position + 7'd1;
    end else begin
      if (record_position < 6'(bsd_pkg::WORD_BYTES)) begin
        case (record_position[1:0])
          2'd0: partial_word_next = {16'd0, data_byte};
          2'd1: partial_word_next = partial_word | {8'd0, data_byte, 8'd0};
          2'd2: partial_word_next = partial_word | {data_byte, 16'd0};
          default: word_hit = below_count;
        endcase
      end
      if (record_position >= 6'(bsd_pkg::RECORD_BYTES - 1)) begin
        if (below_count) begin
          triangles_seen_next = triangles_seen + 32'd1;
        end else begin
          excess_seen_next = 1'b1;
        end
        record_position_next = '0;
      end else begin
        record_position_next = record_position + 6'd1;
      end
    end

    res_valid = word_hit || final_byte;

    if (final_byte) begin
      res.result_kind     = bsd_pkg::KIND_STATUS;
      res.float_word      = '0;
      res.word_slot       = '0;
      res.triangle_number = '0;
      if (header_position_next < 7'(bsd_pkg::PREAMBLE_BYTES)) begin
        res.file_status = bsd_pkg::STATUS_SHORT;
      end else if (record_position_next == '0 && !excess_seen_next &&
                   triangles_seen_next == declared_count_next) begin
        res.file_status = bsd_pkg::STATUS_OK;
      end else begin
        res.file_status = bsd_pkg::STATUS_MISMATCH;
      end
      header_position_next = '0;
      declared_count_next  = '0;
      record_position_next = '0;
      triangles_seen_next  = '0;
      partial_word_next    = '0;
      excess_seen_next     = 1'b0;
    end
  end

endmodule

### hdl/bsd_out_stage.sv
// bsd_out_stage: result register with a skid entry behind it
// depends on bsd_pkg and bsd_stream_if; drives the result channel
module bsd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsd_pkg::result_t  res,
  output logic              ready_up,
  bsd_out_if.source         result_out
);

  logic             main_valid;
  logic             skid_valid;
  bsd_pkg::result_t main_data;
  bsd_pkg::result_t skid_data;
  logic             pop;

  assign pop      = main_valid && result_out.ready;
  assign ready_up = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : res;
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign result_out.valid           = main_valid;
  assign result_out.result_kind     = main_data.result_kind;
  assign result_out.float_word      = main_data.float_word;
  assign result_out.word_slot       = main_data.word_slot;
  assign result_out.triangle_number = main_data.triangle_number;
  assign result_out.file_status     = main_data.file_status;

endmodule

### hdl/binary_stl_deframer_unit.sv
// binary_stl_deframer_unit: top level of the binary stl deframer
// depends on bsd_pkg, bsd_stream_if, bsd_parser and bsd_out_stage
//
// byte_in carries the file one byte per word, final_byte set on the last one.
// the 80-byte header is skipped, bytes 80..83 give the little-endian
// triangle count, and each 50-byte record yields twelve 32-bit words
// (normal xyz, then three vertices xyz) tagged with slot and triangle number.
// words of records beyond the declared count are dropped.
// on the final byte only a status word comes out (ok, too short, size
// mismatch) and the parser returns to the header state; earlier words of a
// bad file have already gone and must be discarded downstream.
// throughput: one byte per cycle while byte_in.ready is high, set by the combinational parser update.
// each result is registered before result_out, in the result register or, behind a stall, the skid entry.
// a stalled receiver holds the result register; one more result fits in
// the skid entry, after which byte_in.ready drops until the stall clears.
// rst (synchronous) empties both output entries and clears all parser state.
module binary_stl_deframer_unit (
  input  logic      clk,
  input  logic      rst,
  bsd_in_if.sink    byte_in,
  bsd_out_if.source result_out
);

  logic             accept;
  logic             res_valid;
  logic             ready_up;
  bsd_pkg::result_t res;

  assign byte_in.ready = ready_up;
  assign accept        = byte_in.valid && ready_up;

  bsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (byte_in.data_byte),
    .final_byte (byte_in.final_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  bsd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && res_valid),
    .res        (res),
    .ready_up   (ready_up),
    .result_out (result_out)
  );

endmodule

### hdl/bsd_checker.sv
// bsd_checker: port-level checks on the deframer, bound to the top level
// depends on bsd_pkg; sees only the top level's ports
module bsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_float,
  input logic [3:0]  out_slot,
  input logic [31:0] out_tri,
  input logic [1:0]  out_status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == bsd_pkg::KIND_WORD |->
      out_slot <= 4'd11 && out_status == bsd_pkg::STATUS_OK)
    else $error("bad data word fields");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == bsd_pkg::KIND_STATUS |->
      out_float == '0 && out_slot == '0 && out_tri == '0 && out_status != 2'd3)
    else $error("bad status word fields");

endmodule

bind binary_stl_deframer_unit bsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (byte_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_kind   (result_out.result_kind),
  .out_float  (result_out.float_word),
  .out_slot   (result_out.word_slot),
  .out_tri    (result_out.triangle_number),
  .out_status (result_out.file_status)
);

### bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for binary_stl_deframer_unit, binary stl files sent byte by byte
// depends on bsd_pkg, bsd_stream_if and the deframer rtl; a class tracks parser state
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 1850;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  class stl_frame_board;
    logic [6:0]       hdr_pos;
    logic [31:0]      count;
    logic [5:0]       rec_pos;
    logic [31:0]      tri_seen;
    logic [23:0]      partial;
    bit               excess;
    bsd_pkg::result_t due_results[$];
    int unsigned      mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      hdr_pos  = '0;
      count    = '0;
      rec_pos  = '0;
      tri_seen = '0;
      partial  = '0;
      excess   = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      bsd_pkg::result_t r;
      bit               have;
      int unsigned      idx;
      r    = '0;
      have = 1'b0;
      if (hdr_pos < bsd_pkg::PREAMBLE_BYTES) begin
        if (hdr_pos >= bsd_pkg::HEADER_BYTES) begin
          idx = hdr_pos - bsd_pkg::HEADER_BYTES;
          count[8*idx +: 8] = b;
        end
        hdr_pos = hdr_pos + 1'b1;
      end else begin
        if (rec_pos < bsd_pkg::WORD_BYTES) begin
          case (rec_pos[1:0])
            2'd0: partial = {16'h0000, b};
            2'd1: partial[15:8] = b;
            2'd2: partial[23:16] = b;
            default: begin
              // word only goes out while the record is within the count
              if (tri_seen < count) begin
                have              = 1'b1;
                r.result_kind     = bsd_pkg::KIND_WORD;
                r.float_word      = {b, partial};
                r.word_slot       = rec_pos[5:2];
                r.triangle_number = tri_seen;
                r.file_status     = bsd_pkg::STATUS_OK;
              end
            end
          endcase
        end
        if (rec_pos == bsd_pkg::RECORD_BYTES - 1) begin
          if (tri_seen < count) tri_seen = tri_seen + 1;
          else excess = 1'b1;
          rec_pos = '0;
        end else begin
          rec_pos = rec_pos + 1'b1;
        end
      end

      if (last) begin
        r             = '0;
        r.result_kind = bsd_pkg::KIND_STATUS;
        if (hdr_pos < bsd_pkg::PREAMBLE_BYTES) r.file_status = bsd_pkg::STATUS_SHORT;
        else if (rec_pos == 0 && !excess && tri_seen == count)
          r.file_status = bsd_pkg::STATUS_OK;
        else r.file_status = bsd_pkg::STATUS_MISMATCH;
        clear_state();
        due_results = {due_results, r};
      end else if (have) begin
        due_results = {due_results, r};
      end
    endfunction

    function void check_result(bsd_pkg::result_t got);
      bsd_pkg::result_t want;
      if (due_results.size() == 0) begin
        $error("result_kind: expected none, got %0d", got.result_kind);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        mismatches++;
      end
      if (got.float_word !== want.float_word) begin
        $error("float_word: expected %08h, got %08h", want.float_word, got.float_word);
        mismatches++;
      end
      if (got.word_slot !== want.word_slot) begin
        $error("word_slot: expected %0d, got %0d", want.word_slot, got.word_slot);
        mismatches++;
      end
      if (got.triangle_number !== want.triangle_number) begin
        $error("triangle_number: expected %0d, got %0d", want.triangle_number,
               got.triangle_number);
        mismatches++;
      end
      if (got.file_status !== want.file_status) begin
        $error("file_status: expected %0d, got %0d", want.file_status, got.file_status);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  bit               no_gaps;
  int unsigned      cycles = 0;
  int unsigned      bytes_sent;
  bsd_pkg::result_t seen;
  stl_frame_board   board;

  bsd_in_if  byte_in ();
  bsd_out_if result_out ();

  binary_stl_deframer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .result_out (result_out)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
        seen.result_kind     = bsd_pkg::kind_t'(result_out.result_kind);
        seen.float_word      = result_out.float_word;
        seen.word_slot       = result_out.word_slot;
        seen.triangle_number = result_out.triangle_number;
        seen.file_status     = bsd_pkg::status_t'(result_out.file_status);
        board.check_result(seen);
      end
      if (byte_in.valid === 1'b1 && byte_in.ready === 1'b1) begin
        board.take_byte(byte_in.data_byte, byte_in.final_byte);
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    result_out.ready <= 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall != 0) begin
        result_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_out.ready <= 1'b1;
      do @(posedge clk); while (!(result_out.valid === 1'b1 && result_out.ready === 1'b1));
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_in.valid      <= 1'b1;
    byte_in.data_byte  <= b;
    byte_in.final_byte <= last;
    do @(posedge clk); while (byte_in.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_file(logic [31:0] tri_count, int unsigned length, fill_t fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < length; i++) begin
      if (i >= bsd_pkg::HEADER_BYTES && i < bsd_pkg::PREAMBLE_BYTES)
        b = tri_count[8*(i-bsd_pkg::HEADER_BYTES) +: 8];
      else if (fill == FILL_ZERO) b = 8'h00;
      else if (fill == FILL_ONES) b = 8'hFF;
      else b = 8'($urandom);
      send_byte(b, i == length - 1);
    end
  endtask

  initial begin
    logic [31:0] tri_count;
    int unsigned len;
    int unsigned n;
    board              = new();
    clk                = 1'b0;
    rst                = 1'b1;
    no_gaps            = 1'b0;
    bytes_sent         = 0;
    byte_in.valid      <= 1'b0;
    byte_in.data_byte  <= 8'h00;
    byte_in.final_byte <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // short files, then good, mismatched, excess and truncated ones
    send_file(32'd0, 1, FILL_RANDOM);
    send_file(32'd0, 83, FILL_ZERO);
    send_file(32'hFFFF_FFFF, 82, FILL_ONES);
    send_file(32'd0, bsd_pkg::PREAMBLE_BYTES, FILL_ZERO);
    send_file(32'd1, bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES, FILL_ONES);
    send_file(32'd1, bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES, FILL_ZERO);
    send_file(32'd3, bsd_pkg::PREAMBLE_BYTES + 3 * bsd_pkg::RECORD_BYTES, FILL_RANDOM);
    send_file(32'd2, bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES, FILL_RANDOM);
    send_file(32'd0, bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES, FILL_RANDOM);
    send_file(32'd1, bsd_pkg::PREAMBLE_BYTES + 2 * bsd_pkg::RECORD_BYTES, FILL_RANDOM);
    send_file(32'd2, bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES + 30, FILL_RANDOM);
    send_file(32'd1, bsd_pkg::PREAMBLE_BYTES + 48, FILL_RANDOM);
    send_file(32'd1, bsd_pkg::PREAMBLE_BYTES + 1, FILL_RANDOM);
    send_file(32'hFFFF_FFFF, bsd_pkg::PREAMBLE_BYTES + 2 * bsd_pkg::RECORD_BYTES,
              FILL_RANDOM);

    while (bytes_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      n       = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        9: begin
          len       = $urandom_range(1, bsd_pkg::PREAMBLE_BYTES - 1);
          tri_count = $urandom;
        end
        8: begin
          len       = bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES * n
                      + $urandom_range(1, bsd_pkg::RECORD_BYTES - 1);
          tri_count = n + $urandom_range(0, 1);
        end
        7: begin
          len       = bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES * n;
          tri_count = $urandom_range(0, 1) ? $urandom : n + $urandom_range(1, 3);
        end
        6: begin
          tri_count = $urandom_range(0, 2);
          len       = bsd_pkg::PREAMBLE_BYTES
                      + bsd_pkg::RECORD_BYTES * (tri_count + $urandom_range(1, 2));
        end
        default: begin
          len       = bsd_pkg::PREAMBLE_BYTES + bsd_pkg::RECORD_BYTES * n;
          tri_count = n;
        end
      endcase
      send_file(tri_count, len, FILL_RANDOM);
    end

    @(negedge clk);
    byte_in.valid <= 1'b0;
    no_gaps       = 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
